@@ sv/atat_pkg.sv @@
// Shared constants, types and helpers for the affine texel address tiler.
// Used by atat_div_stage and affine_texel_address_tiler_core; no dependencies.
`timescale 1ns / 1ps

package atat_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int FRAC_BITS = 16;

   localparam int COEF_W  = 32;
   localparam int PIX_W   = 12;
   localparam int TEX_W   = 12;
   localparam int CSR_IDX_W = 3;
   localparam int MODE_W  = 2;

   // coefficient times (2p+1): 32-bit signed by 14-bit signed
   localparam int PROD_W  = COEF_W + PIX_W + 2;
   // two products plus twice the translation
   localparam int SUM_W   = PROD_W + 2;
   // floored coordinate after dropping the fraction and the half-pixel bit
   localparam int COORD_W = SUM_W - FRAC_BITS - 1;
   // magnitude of the coordinate after folding negatives with one's complement
   localparam int MAG_W   = COORD_W - 1;

   localparam int SIZE_W  = $clog2(MAX_DIM) + 1;

   // restoring divider layout
   localparam int DIV_STEPS  = 8;
   localparam int DIV_STAGES = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_W      = DIV_STAGES * DIV_STEPS;

   // pipeline stage positions
   localparam int ST_MUL  = 0;
   localparam int ST_SUM  = 1;
   localparam int ST_DIV0 = 2;
   localparam int ST_OUT  = ST_DIV0 + DIV_STAGES;
   localparam int NSTAGE  = ST_OUT + 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INV_A       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_B       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_C       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_D       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_E       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_F       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BITMAP_SIZE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_MODE   = 3'd7;

   // tile modes; the unused code behaves as clamp
   localparam logic [MODE_W-1:0] TILE_CLAMP  = 2'd0;
   localparam logic [MODE_W-1:0] TILE_REPEAT = 2'd1;
   localparam logic [MODE_W-1:0] TILE_MIRROR = 2'd2;

   localparam logic [COEF_W-1:0] INV_ONE        = 32'h0001_0000;
   localparam logic [COEF_W-1:0] BITMAP_SIZE_RST = 32'h0001_0001;

   // per-transaction fields that ride alongside the divider
   typedef struct packed {
      logic              neg_x;
      logic              neg_y;
      logic [SIZE_W-1:0] clamp_x;
      logic [SIZE_W-1:0] clamp_y;
      logic              span;
   } side_type;

   // zero reads as one, anything above the maximum reads as the maximum
   function automatic logic [SIZE_W-1:0] fix_size(input logic [15:0] s);
      logic [SIZE_W-1:0] r;
      if (s == 16'd0) begin
         r = SIZE_W'(1);
      end else if (32'(s) > 32'(MAX_DIM)) begin
         r = SIZE_W'(MAX_DIM);
      end else begin
         r = SIZE_W'(s);
      end
      return r;
   endfunction

endpackage

@@ sv/atat_div_stage.sv @@
// One registered slice of the pipelined restoring divider (DIV_STEPS quotient bits).
// Depends on atat_pkg.
`timescale 1ns / 1ps

module atat_div_stage (
   input  logic                        clock,
   input  logic                        load,
   input  logic [atat_pkg::DIV_W-1:0]  quo_i,
   input  logic [atat_pkg::SIZE_W-1:0] rem_i,
   input  logic [atat_pkg::SIZE_W-1:0] size_i,
   output logic [atat_pkg::DIV_W-1:0]  quo_o,
   output logic [atat_pkg::SIZE_W-1:0] rem_o
);

   logic [atat_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [atat_pkg::SIZE_W-1:0] rem_ff, rem_in;

   // dividend bits leave at the top of quo while quotient bits enter at the bottom
   always_comb begin
      logic [atat_pkg::SIZE_W:0] trial;
      quo_in = quo_i;
      rem_in = rem_i;
      for (int i = 0; i < atat_pkg::DIV_STEPS; i++) begin
         trial  = {rem_in, quo_in[atat_pkg::DIV_W-1]};
         quo_in = quo_in << 1;
         if (trial >= {1'b0, size_i}) begin
            trial     = trial - {1'b0, size_i};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[atat_pkg::SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quo_o = quo_ff;
   assign rem_o = rem_ff;

endmodule

@@ sv/affine_texel_address_tiler_core.sv @@
// Affine texel address tiler: pixel to texel mapping with clamp/repeat/mirror.
// Depends on atat_pkg and atat_div_stage.
`timescale 1ns / 1ps

// Maps each destination pixel center through the inverse affine matrix (signed
// 16.16), floors it and folds each axis into the bitmap size by tile mode. The
// pipeline is seven stages deep: coefficient multiply, sum and floor, four
// restoring divider slices (eight quotient bits each, for the modulo and the
// mirror period), then the final fold. One transaction is accepted every cycle
// unless response stalls fill every stage; each passes the stage registers in
// order, and rsp_valid comes from the final fold register. Stalls on the response
// side back up one stage at a time, so empty stages keep filling. The user must
// write registers only while no transaction is in flight; nothing enforces it.
module affine_texel_address_tiler_core (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [atat_pkg::PIX_W-1:0]     req_pixel_x,
   input  logic [atat_pkg::PIX_W-1:0]     req_pixel_y,
   input  logic                           req_span_end,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [atat_pkg::TEX_W-1:0]     rsp_texel_x,
   output logic [atat_pkg::TEX_W-1:0]     rsp_texel_y,
   output logic                           rsp_last_of_span,

   input  logic                           csr_we,
   input  logic [atat_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [atat_pkg::COEF_W-1:0]    csr_wdata
);

   // ---------------- configuration registers ----------------
   logic signed [atat_pkg::COEF_W-1:0] inv_a_ff, inv_b_ff, inv_c_ff;
   logic signed [atat_pkg::COEF_W-1:0] inv_d_ff, inv_e_ff, inv_f_ff;
   logic [atat_pkg::COEF_W-1:0]        bitmap_size_ff;
   logic [atat_pkg::MODE_W-1:0]        tile_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_a_ff       <= atat_pkg::INV_ONE;
         inv_b_ff       <= '0;
         inv_c_ff       <= '0;
         inv_d_ff       <= '0;
         inv_e_ff       <= atat_pkg::INV_ONE;
         inv_f_ff       <= '0;
         bitmap_size_ff <= atat_pkg::BITMAP_SIZE_RST;
         tile_mode_ff   <= atat_pkg::TILE_CLAMP;
      end else if (csr_we) begin
         unique case (csr_index)
            atat_pkg::CSR_INV_A:       inv_a_ff       <= csr_wdata;
            atat_pkg::CSR_INV_B:       inv_b_ff       <= csr_wdata;
            atat_pkg::CSR_INV_C:       inv_c_ff       <= csr_wdata;
            atat_pkg::CSR_INV_D:       inv_d_ff       <= csr_wdata;
            atat_pkg::CSR_INV_E:       inv_e_ff       <= csr_wdata;
            atat_pkg::CSR_INV_F:       inv_f_ff       <= csr_wdata;
            atat_pkg::CSR_BITMAP_SIZE: bitmap_size_ff <= csr_wdata;
            atat_pkg::CSR_TILE_MODE:   tile_mode_ff   <= csr_wdata[atat_pkg::MODE_W-1:0];
         endcase
      end
   end

   logic [atat_pkg::SIZE_W-1:0] size_x, size_y;
   assign size_x = atat_pkg::fix_size(bitmap_size_ff[15:0]);
   assign size_y = atat_pkg::fix_size(bitmap_size_ff[31:16]);

   // ---------------- stage valids and per-stage enables ----------------
   logic [atat_pkg::NSTAGE-1:0] valid_ff, valid_in, en;

   always_comb begin
      en[atat_pkg::ST_OUT] = ~valid_ff[atat_pkg::ST_OUT] | rsp_ready;
      for (int k = atat_pkg::ST_OUT - 1; k >= 0; k--) begin
         en[k] = ~valid_ff[k] | en[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < atat_pkg::NSTAGE; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < atat_pkg::NSTAGE; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_ready = en[atat_pkg::ST_MUL];

   // ---------------- stage 1: coefficient products ----------------
   // pixel center times two is 2p+1, so the sum carries one extra fraction bit
   logic signed [atat_pkg::PIX_W+1:0]   x2p1_s, y2p1_s;
   logic signed [atat_pkg::PROD_W-1:0]  prod_ax_ff, prod_by_ff, prod_dx_ff, prod_ey_ff;
   logic signed [atat_pkg::PROD_W-1:0]  prod_ax_in, prod_by_in, prod_dx_in, prod_ey_in;
   logic                                span_mul_ff;

   assign x2p1_s     = {1'b0, req_pixel_x, 1'b1};
   assign y2p1_s     = {1'b0, req_pixel_y, 1'b1};
   assign prod_ax_in = inv_a_ff * x2p1_s;
   assign prod_by_in = inv_b_ff * y2p1_s;
   assign prod_dx_in = inv_d_ff * x2p1_s;
   assign prod_ey_in = inv_e_ff * y2p1_s;

   always_ff @(posedge clock) begin
      if (en[atat_pkg::ST_MUL]) begin
         prod_ax_ff  <= prod_ax_in;
         prod_by_ff  <= prod_by_in;
         prod_dx_ff  <= prod_dx_in;
         prod_ey_ff  <= prod_ey_in;
         span_mul_ff <= req_span_end;
      end
   end

   // ---------------- stage 2: sum, floor, fold sign, clamp ----------------
   logic signed [atat_pkg::SUM_W-1:0] sum_u, sum_v;
   logic [atat_pkg::COORD_W-1:0]      coord_u, coord_v, mag_full_u, mag_full_v;
   logic [atat_pkg::MAG_W-1:0]        mag_u, mag_v;
   logic                              neg_u, neg_v;
   logic [atat_pkg::SIZE_W-1:0]       clamp_u_in, clamp_v_in;

   assign sum_u = atat_pkg::SUM_W'(prod_ax_ff) + atat_pkg::SUM_W'(prod_by_ff)
                + (atat_pkg::SUM_W'(inv_c_ff) <<< 1);
   assign sum_v = atat_pkg::SUM_W'(prod_dx_ff) + atat_pkg::SUM_W'(prod_ey_ff)
                + (atat_pkg::SUM_W'(inv_f_ff) <<< 1);

   // dropping low bits of a two's complement value is a floor
   assign coord_u    = sum_u[atat_pkg::SUM_W-1:atat_pkg::FRAC_BITS+1];
   assign coord_v    = sum_v[atat_pkg::SUM_W-1:atat_pkg::FRAC_BITS+1];
   assign neg_u      = coord_u[atat_pkg::COORD_W-1];
   assign neg_v      = coord_v[atat_pkg::COORD_W-1];
   // -1-f for negatives: mirror uses it directly, repeat flips the remainder later
   assign mag_full_u = neg_u ? ~coord_u : coord_u;
   assign mag_full_v = neg_v ? ~coord_v : coord_v;
   assign mag_u      = mag_full_u[atat_pkg::MAG_W-1:0];
   assign mag_v      = mag_full_v[atat_pkg::MAG_W-1:0];

   always_comb begin
      if (neg_u) begin
         clamp_u_in = '0;
      end else if (mag_u >= atat_pkg::MAG_W'(size_x)) begin
         clamp_u_in = size_x - atat_pkg::SIZE_W'(1);
      end else begin
         clamp_u_in = coord_u[atat_pkg::SIZE_W-1:0];
      end
      if (neg_v) begin
         clamp_v_in = '0;
      end else if (mag_v >= atat_pkg::MAG_W'(size_y)) begin
         clamp_v_in = size_y - atat_pkg::SIZE_W'(1);
      end else begin
         clamp_v_in = coord_v[atat_pkg::SIZE_W-1:0];
      end
   end

   logic [atat_pkg::DIV_W-1:0] dvd_u_ff, dvd_v_ff;
   atat_pkg::side_type         side_sum_ff;

   always_ff @(posedge clock) begin
      if (en[atat_pkg::ST_SUM]) begin
         dvd_u_ff            <= atat_pkg::DIV_W'(mag_u);
         dvd_v_ff            <= atat_pkg::DIV_W'(mag_v);
         side_sum_ff.neg_x   <= neg_u;
         side_sum_ff.neg_y   <= neg_v;
         side_sum_ff.clamp_x <= clamp_u_in;
         side_sum_ff.clamp_y <= clamp_v_in;
         side_sum_ff.span    <= span_mul_ff;
      end
   end

   // ---------------- divider stages ----------------
   logic [atat_pkg::DIV_W-1:0]  quo_u [atat_pkg::DIV_STAGES];
   logic [atat_pkg::DIV_W-1:0]  quo_v [atat_pkg::DIV_STAGES];
   logic [atat_pkg::SIZE_W-1:0] rem_u [atat_pkg::DIV_STAGES];
   logic [atat_pkg::SIZE_W-1:0] rem_v [atat_pkg::DIV_STAGES];
   atat_pkg::side_type          side_ff [atat_pkg::DIV_STAGES];

   for (genvar k = 0; k < atat_pkg::DIV_STAGES; k++) begin : g_div
      logic [atat_pkg::DIV_W-1:0]  quo_u_src, quo_v_src;
      logic [atat_pkg::SIZE_W-1:0] rem_u_src, rem_v_src;
      atat_pkg::side_type          side_src;

      if (k == 0) begin : g_first
         assign quo_u_src = dvd_u_ff;
         assign quo_v_src = dvd_v_ff;
         assign rem_u_src = '0;
         assign rem_v_src = '0;
         assign side_src  = side_sum_ff;
      end else begin : g_next
         assign quo_u_src = quo_u[k-1];
         assign quo_v_src = quo_v[k-1];
         assign rem_u_src = rem_u[k-1];
         assign rem_v_src = rem_v[k-1];
         assign side_src  = side_ff[k-1];
      end

      atat_div_stage u_div_x (
         .clock  (clock),
         .load   (en[atat_pkg::ST_DIV0+k]),
         .quo_i  (quo_u_src),
         .rem_i  (rem_u_src),
         .size_i (size_x),
         .quo_o  (quo_u[k]),
         .rem_o  (rem_u[k])
      );

      atat_div_stage u_div_y (
         .clock  (clock),
         .load   (en[atat_pkg::ST_DIV0+k]),
         .quo_i  (quo_v_src),
         .rem_i  (rem_v_src),
         .size_i (size_y),
         .quo_o  (quo_v[k]),
         .rem_o  (rem_v[k])
      );

      always_ff @(posedge clock) begin
         if (en[atat_pkg::ST_DIV0+k]) begin
            side_ff[k] <= side_src;
         end
      end
   end

   // ---------------- final fold ----------------
   localparam int LAST = atat_pkg::DIV_STAGES - 1;

   logic [atat_pkg::SIZE_W-1:0] rem_x, rem_y, tex_x_full, tex_y_full;
   logic                        flip_x, flip_y;
   atat_pkg::side_type          side_last;

   assign rem_x     = rem_u[LAST];
   assign rem_y     = rem_v[LAST];
   assign side_last = side_ff[LAST];

   always_comb begin
      case (tile_mode_ff)
         atat_pkg::TILE_REPEAT: begin
            flip_x = side_last.neg_x;
            flip_y = side_last.neg_y;
         end
         atat_pkg::TILE_MIRROR: begin
            // odd period reflects
            flip_x = quo_u[LAST][0];
            flip_y = quo_v[LAST][0];
         end
         default: begin
            flip_x = 1'b0;
            flip_y = 1'b0;
         end
      endcase

      if (tile_mode_ff == atat_pkg::TILE_REPEAT || tile_mode_ff == atat_pkg::TILE_MIRROR) begin
         tex_x_full = flip_x ? (size_x - atat_pkg::SIZE_W'(1) - rem_x) : rem_x;
         tex_y_full = flip_y ? (size_y - atat_pkg::SIZE_W'(1) - rem_y) : rem_y;
      end else begin
         tex_x_full = side_last.clamp_x;
         tex_y_full = side_last.clamp_y;
      end
   end

   logic [atat_pkg::TEX_W-1:0] texel_x_ff, texel_y_ff;
   logic                       last_of_span_ff;

   always_ff @(posedge clock) begin
      if (en[atat_pkg::ST_OUT]) begin
         texel_x_ff      <= atat_pkg::TEX_W'(tex_x_full);
         texel_y_ff      <= atat_pkg::TEX_W'(tex_y_full);
         last_of_span_ff <= side_last.span;
      end
   end

   assign rsp_valid        = valid_ff[atat_pkg::ST_OUT];
   assign rsp_texel_x      = texel_x_ff;
   assign rsp_texel_y      = texel_y_ff;
   assign rsp_last_of_span = last_of_span_ff;

   // ---------------- assertions ----------------
   a_rem_in_range : assert property (@(posedge clock) disable iff (reset)
      valid_ff[atat_pkg::ST_OUT-1] |-> (rem_x < size_x) && (rem_y < size_y))
      else $error("divider remainder not below size");

   a_texel_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (atat_pkg::SIZE_W'(rsp_texel_x) < size_x)
                 && (atat_pkg::SIZE_W'(rsp_texel_y) < size_y))
      else $error("texel coordinate outside bitmap");

   a_neg_clamps_zero : assert property (@(posedge clock) disable iff (reset)
      valid_ff[atat_pkg::ST_SUM] && side_sum_ff.neg_x |-> side_sum_ff.clamp_x == '0)
      else $error("negative coordinate did not clamp to zero");

   a_ready_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> valid_ff[atat_pkg::ST_MUL] && !en[atat_pkg::ST_SUM])
      else $error("input stalled with room in the pipeline");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(texel_x_ff) && $stable(texel_y_ff))
      else $error("stalled transaction lost or changed");

endmodule
